>>> sv/rid_pkg.sv
// Package for the real-input DFT: widths, twiddle types and the twiddle ROM builder.
package rid_pkg;

	localparam int MaxPoints = 64;
	localparam int DefPoints = 64;
	localparam int SampleW   = 16;
	localparam int TwW       = 16;
	localparam int ProdW     = SampleW + TwW;
	localparam int AccW      = 38;
	localparam int ResultW   = 22;
	localparam int BinW      = 6;
	localparam int RomIdxW   = 6;
	localparam int FracW     = 15;

	typedef logic [MaxPoints-1:0][TwW-1:0] tw_rom_t;

	localparam logic [63:0] PiQ60  = 64'h3243F6A8885A308D;
	localparam logic [63:0] Q62One = 64'h4000000000000000;

	// (x*y) >> 62, kept to 64 bits
	function automatic logic [63:0] mulq62(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return p[125:62];
	endfunction

	// restoring shift-subtract divide, used only while elaborating the ROM
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], a[i]};
			if (rem >= {1'b0, b}) begin
				rem  = rem - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// angle r*(pi/4)/n in Q62
	function automatic logic [63:0] octant_angle(input logic [63:0] r, input logic [63:0] n);
		logic [63:0] q;
		logic [63:0] rm;
		q  = udiv64(PiQ60, n);
		rm = PiQ60 - q * n;
		return q * r + udiv64(rm * r, n);
	endfunction

	// Taylor series on [0, pi/4], Q62
	function automatic logic [63:0] series(input logic [63:0] a, input logic want_sin);
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] d;
		a2   = mulq62(a, a);
		term = want_sin ? a : Q62One;
		sum  = term;
		for (int i = 1; i <= 14; i++) begin
			d    = want_sin ? 64'((2 * i) * (2 * i + 1)) : 64'((2 * i - 1) * (2 * i));
			term = udiv64(mulq62(term, a2), d);
			if ((i % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	// Q62 magnitude to 32767 scale, round half away from zero
	function automatic int to_q15(input logic [63:0] mag);
		logic [63:0] v;
		v = ((mag >> 16) * 64'd32767 + (64'd1 << 45) + (64'd1 << 20)) >> 46;
		return int'(v[15:0]);
	endfunction

	// cos or sin table for an n-point transform, entries past n are zero
	function automatic tw_rom_t build_rom(input int n, input logic want_sin);
		tw_rom_t rom;
		int p;
		int oct;
		int quad;
		int cq;
		int sq;
		int cv;
		int sv;
		logic [63:0] a;
		logic [63:0] c;
		logic [63:0] s;
		rom = '0;
		for (int k = 0; k < MaxPoints; k++) begin
			if (k < n) begin
				p   = 8 * k;
				oct = 0;
				for (int j = 0; j < 8; j++) begin
					if (p >= n) begin
						p   = p - n;
						oct = oct + 1;
					end
				end
				quad = (oct >> 1) & 3;
				if ((oct & 1) == 0) begin
					a = octant_angle(64'(p), 64'(n));
					c = series(a, 1'b0);
					s = series(a, 1'b1);
				end else begin
					a = octant_angle(64'(n - p), 64'(n));
					c = series(a, 1'b1);
					s = series(a, 1'b0);
				end
				cq = to_q15(c);
				sq = to_q15(s);
				case (quad)
					0: begin cv = cq;  sv = sq;  end
					1: begin cv = -sq; sv = cq;  end
					2: begin cv = -cq; sv = -sq; end
					default: begin cv = sq; sv = -cq; end
				endcase
				rom[k] = want_sin ? TwW'(sv) : TwW'(cv);
			end
		end
		return rom;
	endfunction

endpackage

>>> sv/rid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rid_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/real_input_dft.sv
// Top level: direct DFT of a frame of real samples, one MAC per cycle over a sample RAM.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-------------------------------
//  input    | sample                                       | start & !busy accepts an item
//  result   | bin_index, real_part, imag_part, last_bin    | result_valid, one cycle, no stall
//
// Cycles: a sample is taken every cycle while busy is low. The item that carries the
// last sample of a frame starts the transform: POINTS*POINTS multiply-accumulates,
// one per cycle, set by the single read port of the sample RAM and the one MAC unit,
// then the pipeline drains. busy stays high over that span, so samples of the next
// frame are not taken until the transform is done.
// Reset: arst_n clears the fill count, the sequencer and the pipeline flags; the
// sample RAM is not cleared and is only read after a full frame was written.
// Stalls: none; each bin comes out as a one-cycle strobe in order m = 0..POINTS-1.
module real_input_dft
	import rid_pkg::*;
#(
	parameter int POINTS = DefPoints
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [SampleW-1:0] sample,
	output logic                      result_valid,
	output logic [BinW-1:0]           bin_index,
	output logic signed [ResultW-1:0] real_part,
	output logic signed [ResultW-1:0] imag_part,
	output logic                      last_bin
);

	localparam int IdxW = $clog2(POINTS);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(POINTS - 1);
	localparam logic [IdxW:0]   NPoints = (IdxW + 1)'(POINTS);

	// twiddles for this transform length, fixed at elaboration
	localparam tw_rom_t CosRom = build_rom(POINTS, 1'b0);
	localparam tw_rom_t SinRom = build_rom(POINTS, 1'b1);

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_CALC  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;

	// frame fill and MAC loop counters
	logic [IdxW-1:0] fill_q;
	logic [IdxW-1:0] n_q;
	logic [IdxW-1:0] m_q;
	logic [IdxW-1:0] k_q;   // (n*m) mod POINTS, stepped by m
	logic [IdxW:0]   k_sum;
	logic [IdxW-1:0] k_next;

	logic accept;
	logic issue;

	// RAM interface
	logic [SampleW-1:0] rd_data;

	// stage 1: RAM data and twiddle index
	logic            vld_s1;
	logic            first_s1;
	logic            last_s1;
	logic [IdxW-1:0] m_s1;
	logic [IdxW-1:0] k_s1;
	logic signed [TwW-1:0] tw_cos;
	logic signed [TwW-1:0] tw_sin;

	// stage 2: products
	logic                    vld_s2;
	logic                    first_s2;
	logic                    last_s2;
	logic [IdxW-1:0]         m_s2;
	logic signed [ProdW-1:0] prod_re_s2;
	logic signed [ProdW-1:0] prod_im_s2;

	// accumulators
	logic signed [AccW-1:0] acc_re_q;
	logic signed [AccW-1:0] acc_im_q;
	logic signed [AccW-1:0] acc_re_nxt;
	logic signed [AccW-1:0] acc_im_nxt;
	logic                   frame_end;

	// result registers
	logic                      res_valid_q;
	logic [BinW-1:0]           bin_q;
	logic signed [ResultW-1:0] real_q;
	logic signed [ResultW-1:0] imag_q;
	logic                      last_q;

	assign busy   = (state_q != ST_LOAD);
	assign accept = start && (state_q == ST_LOAD);
	assign issue  = (state_q == ST_CALC);

	// k steps by m with one compare-subtract, since k + m < 2*POINTS
	assign k_sum  = {1'b0, k_q} + {1'b0, m_q};
	assign k_next = (k_sum >= NPoints) ? IdxW'(k_sum - NPoints) : k_sum[IdxW-1:0];

	rid_ram #(
		.WIDTH(SampleW),
		.DEPTH(POINTS)
	) u_sample_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(fill_q),
		.wdata(sample),
		.re   (issue),
		.raddr(n_q),
		.rdata(rd_data)
	);

	// sequencer: load a frame, then walk m outer, n inner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			n_q     <= '0;
			m_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (fill_q == LastIdx) begin
							fill_q  <= '0;
							n_q     <= '0;
							m_q     <= '0;
							k_q     <= '0;
							state_q <= ST_CALC;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_CALC: begin
					if (n_q == LastIdx) begin
						n_q <= '0;
						k_q <= '0;
						m_q <= m_q + 1'b1;
						if (m_q == LastIdx) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						n_q <= n_q + 1'b1;
						k_q <= k_next;
					end
				end
				ST_DRAIN: begin
					if (frame_end) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			vld_s1      <= issue;
			vld_s2      <= vld_s1;
			res_valid_q <= vld_s2 && last_s2;
		end
	end

	assign tw_cos = $signed(CosRom[RomIdxW'(k_s1)]);
	assign tw_sin = $signed(SinRom[RomIdxW'(k_s1)]);

	// pipeline payload
	always_ff @(posedge clk) begin
		first_s1   <= (n_q == '0);
		last_s1    <= (n_q == LastIdx);
		m_s1       <= m_q;
		k_s1       <= k_q;
		first_s2   <= first_s1;
		last_s2    <= last_s1;
		m_s2       <= m_s1;
		prod_re_s2 <= $signed(rd_data) * tw_cos;
		prod_im_s2 <= $signed(rd_data) * tw_sin;
	end

	// exact sums; the imaginary part accumulates the negated sine products
	assign acc_re_nxt = (first_s2 ? AccW'(0) : acc_re_q) + AccW'(prod_re_s2);
	assign acc_im_nxt = (first_s2 ? AccW'(0) : acc_im_q) - AccW'(prod_im_s2);
	assign frame_end  = vld_s2 && last_s2 && (m_s2 == LastIdx);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_re_q <= acc_re_nxt;
			acc_im_q <= acc_im_nxt;
		end
		if (vld_s2 && last_s2) begin
			// arithmetic shift right by 15 is floor division
			real_q <= acc_re_nxt[ResultW+FracW-1:FracW];
			imag_q <= acc_im_nxt[ResultW+FracW-1:FracW];
			bin_q  <= BinW'(m_s2);
			last_q <= (m_s2 == LastIdx);
		end
	end

	assign result_valid = res_valid_q;
	assign bin_index    = bin_q;
	assign real_part    = real_q;
	assign imag_part    = imag_q;
	assign last_bin     = last_q;

endmodule

>>> bench/testbench.sv
// Testbench for real_input_dft: frames of samples in, per-bin DFT results checked against a predictor.
module testbench;
	import rid_pkg::*;

	// Frame length used for the block under test; also the number of bins per frame.
	localparam int Points = DefPoints;
	// Cycles with no accepted item and no result before the run is declared hung.
	// One frame costs Points*Points MACs plus a short drain, so allow several frames' worth.
	localparam int HangLimit = 8 * (Points * Points + 64);
	// Settling cycles after the last expected bin has come out.
	localparam int DrainCycles = 16;
	localparam int MaxGap = 14;
	localparam int RandomFrames = 3;
	localparam int ReportLimit = 10;
	localparam real TwoPi = 6.283185307179586;

	// Content styles for random frames.
	typedef enum int {
		FULL_RANGE,
		LOW_LEVEL,
		RAILS,
		SPARSE
	} frame_style_e;

	// Idle styles for the sender over one frame.
	typedef enum int {
		NO_IDLE,
		ALWAYS_IDLE,
		SOME_IDLE
	} idle_style_e;

	// One expected bin of a transform.
	typedef struct {
		logic [BinW-1:0]           bin_no;
		logic signed [ResultW-1:0] re;
		logic signed [ResultW-1:0] im;
		logic                      last;
	} bin_result_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic signed [SampleW-1:0] sample = '0;
	logic                      result_valid;
	logic [BinW-1:0]           bin_index;
	logic signed [ResultW-1:0] real_part;
	logic signed [ResultW-1:0] imag_part;
	logic                      last_bin;

	// Predictor state: our own twiddle tables, the frame being filled, and its fill level.
	int                        cos_tw [Points];
	int                        sin_tw [Points];
	logic signed [SampleW-1:0] frame_store [Points];
	int                        fill_level = 0;

	// Bins still owed by the block, oldest first.
	bin_result_t expected_bins[$];

	int mismatches = 0;
	int quiet_cycles = 0;

	real_input_dft #(
		.POINTS(Points)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample       (sample),
		.result_valid (result_valid),
		.bin_index    (bin_index),
		.real_part    (real_part),
		.imag_part    (imag_part),
		.last_bin     (last_bin)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// 32767 * v, rounded to nearest with ties away from zero.
	function automatic int round_q15(input real v);
		real s;
		s = 32767.0 * v;
		if (s >= 0.0) begin
			return int'($floor(s + 0.5));
		end else begin
			return -int'($floor(-s + 0.5));
		end
	endfunction

	// Twiddle tables for the frame length. Quarter-turn points come out exact since
	// the residue of cos/sin there is far below half an LSB.
	function automatic void build_twiddles();
		real ang;
		for (int k = 0; k < Points; k++) begin
			ang = TwoPi * k / Points;
			cos_tw[k] = round_q15($cos(ang));
			sin_tw[k] = round_q15($sin(ang));
		end
	endfunction

	// Full direct DFT of the stored frame; one expected bin per m, in output order.
	// Exact 64-bit sums, then an arithmetic shift: that is the floor the block applies.
	function automatic void predict_bins();
		longint      acc_re;
		longint      acc_im;
		bin_result_t r;
		for (int m = 0; m < Points; m++) begin
			acc_re = 0;
			acc_im = 0;
			for (int n = 0; n < Points; n++) begin
				acc_re += longint'(frame_store[n]) * longint'(cos_tw[(n * m) % Points]);
				acc_im -= longint'(frame_store[n]) * longint'(sin_tw[(n * m) % Points]);
			end
			r.bin_no = BinW'(m);
			r.re     = ResultW'(acc_re >>> FracW);
			r.im     = ResultW'(acc_im >>> FracW);
			r.last   = (m == Points - 1);
			expected_bins.push_back(r);
		end
	endfunction

	// Track one accepted sample; the last one of a frame triggers the transform.
	function automatic void take_sample(input logic signed [SampleW-1:0] value);
		frame_store[fill_level] = value;
		fill_level++;
		if (fill_level == Points) begin
			fill_level = 0;
			predict_bins();
		end
	endfunction

	// Send one item. Optional idle first (start low, junk on sample), then hold start
	// until the block takes it. With no idle, start simply stays high from the last item.
	task automatic send_sample(input logic signed [SampleW-1:0] value, input int max_gap);
		int gap;
		gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
		if (gap > 0) begin
			start  <= 1'b0;
			sample <= SampleW'($urandom);
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (busy) @(posedge clk);
		take_sample(value);
	endtask

	function automatic int gap_for(input idle_style_e style);
		case (style)
			NO_IDLE:     return 0;
			ALWAYS_IDLE: return MaxGap;
			default:     return ($urandom_range(0, 1) != 0) ? MaxGap : 0;
		endcase
	endfunction

	function automatic logic signed [SampleW-1:0] draw_sample(input frame_style_e style);
		logic signed [SampleW-1:0] v;
		case (style)
			FULL_RANGE: v = SampleW'($urandom);
			LOW_LEVEL:  v = SampleW'($signed($urandom_range(0, 511)) - 256);
			RAILS: begin
				// mostly full-scale values, now and then one off by a little
				case ($urandom_range(0, 3))
					0:       v = 16'sh7FFF;
					1:       v = 16'sh8000;
					2:       v = 16'sh7FFF - SampleW'($urandom_range(0, 7));
					default: v = 16'sh8000 + SampleW'($urandom_range(0, 7));
				endcase
			end
			default: v = ($urandom_range(0, 7) == 0) ? SampleW'($urandom) : '0;
		endcase
		return v;
	endfunction

	// Directed: extremes. Alternating rails puts the full swing into the Nyquist bin,
	// then an all-negative frame drives the DC sum close to the bottom of the result
	// range. The second frame is offered while the first transform is still running.
	task automatic test_full_scale();
		for (int n = 0; n < Points; n++) begin
			send_sample((n % 2 == 0) ? 16'sh7FFF : 16'sh8000, 0);
		end
		for (int n = 0; n < Points; n++) begin
			send_sample(16'sh8000, gap_for(SOME_IDLE));
		end
	endtask

	// Random frames: the first spans the whole sample range, the rest pick a style.
	// Idle style also varies per frame so gaps land at every fill level and around busy.
	task automatic test_random_frames();
		frame_style_e fstyle;
		idle_style_e  istyle;
		for (int f = 0; f < RandomFrames; f++) begin
			fstyle = (f == 0) ? FULL_RANGE : frame_style_e'($urandom_range(0, 3));
			istyle = idle_style_e'($urandom_range(0, 2));
			for (int n = 0; n < Points; n++) begin
				send_sample(draw_sample(fstyle), gap_for(istyle));
			end
		end
	endtask

	initial begin
		build_twiddles();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_scale();
		test_random_frames();
		start <= 1'b0;

		while (expected_bins.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Result checker: every strobe must match the oldest owed bin, field by field.
	always @(posedge clk) begin
		bin_result_t exp_bin;
		if (arst_n && result_valid) begin
			if (expected_bins.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit) begin
					$display("unexpected bin %0d: re %0d im %0d last %0b",
						bin_index, real_part, imag_part, last_bin);
				end
			end else begin
				exp_bin = expected_bins.pop_front();
				if (bin_index !== exp_bin.bin_no || real_part !== exp_bin.re ||
						imag_part !== exp_bin.im || last_bin !== exp_bin.last) begin
					mismatches++;
					if (mismatches <= ReportLimit) begin
						$display("bin mismatch: expected idx %0d re %0d im %0d last %0b",
							exp_bin.bin_no, exp_bin.re, exp_bin.im, exp_bin.last);
						$display("              got      idx %0d re %0d im %0d last %0b",
							bin_index, real_part, imag_part, last_bin);
					end
				end
			end
		end
	end

	// Hang detector: counts cycles where neither side moves anything.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= HangLimit) begin
			$display("timeout: no activity for %0d cycles", HangLimit);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

>>> real_input_dft.f
sv/rid_pkg.sv
sv/rid_ram.sv
sv/real_input_dft.sv
bench/testbench.sv
